// ===== sv/r2p_pkg.sv =====
`default_nettype none

package r2p_pkg;

   // Width of each input component and of the magnitude.
   localparam int SAMPLE_WIDTH  = 16;
   // Requested number of CORDIC micro-rotations.
   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int GUARD_BITS    = 24;
   localparam int PHASE_WIDTH   = 16;
   localparam int ANGLE_WIDTH   = 32;

   // Micro-rotations actually built: the arctangent table has 24 entries.
   localparam int CORDIC_USED = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
   // The square root yields one result bit per step.
   localparam int SQRT_STEPS  = SAMPLE_WIDTH;
   localparam int CELL_COUNT  = (CORDIC_USED > SQRT_STEPS) ? CORDIC_USED : SQRT_STEPS;
   localparam int IDX_WIDTH   = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

   // x and y carry the sample scaled by 2^GUARD_BITS plus room for the
   // quadrant fold and the CORDIC gain.
   localparam int XY_WIDTH    = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int RAD_WIDTH   = 2 * SAMPLE_WIDTH;
   localparam int ROOT_WIDTH  = SAMPLE_WIDTH;
   localparam int REM_WIDTH   = SAMPLE_WIDTH + 2;

   localparam logic [ANGLE_WIDTH-1:0] QUARTER_POS = 32'h4000_0000;
   localparam logic [ANGLE_WIDTH-1:0] QUARTER_NEG = 32'hC000_0000;
   localparam logic [ANGLE_WIDTH-1:0] PHASE_HALF  = 32'h0000_8000;

   // atan(2^-i) in units of pi/2^31, rounded to nearest.
   localparam logic [ANGLE_WIDTH-1:0] ATAN_TABLE [ATAN_ENTRIES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   // Everything one cell hands to the next.
   typedef struct packed {
      logic                         zero;
      logic signed [XY_WIDTH-1:0]   x;
      logic signed [XY_WIDTH-1:0]   y;
      logic [ANGLE_WIDTH-1:0]       z;
      logic [RAD_WIDTH-1:0]         rad;
      logic [REM_WIDTH-1:0]         rem;
      logic [ROOT_WIDTH-1:0]        root;
   } cell_data_type;

   function automatic logic [ANGLE_WIDTH-1:0] atan_entry(input int idx);
      logic [ANGLE_WIDTH-1:0] result;
      result = '0;
      if (idx < ATAN_ENTRIES) begin
         result = ATAN_TABLE[idx];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== sv/r2p_channels.sv =====
`default_nettype none

interface r2p_req_if;
   import r2p_pkg::*;
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] real_part;
   logic signed [SAMPLE_WIDTH-1:0] imag_part;

   modport source (output valid, output real_part, output imag_part, input ready);
   modport sink (input valid, input real_part, input imag_part, output ready);
endinterface

interface r2p_rsp_if;
   import r2p_pkg::*;
   logic                          valid;
   logic                          ready;
   logic [SAMPLE_WIDTH-1:0]       magnitude;
   logic signed [PHASE_WIDTH-1:0] phase;

   modport source (output valid, output magnitude, output phase, input ready);
   modport sink (input valid, input magnitude, input phase, output ready);
endinterface

`default_nettype wire

// ===== sv/r2p_front.sv =====
`default_nettype none

module r2p_front (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    advance,
   input  wire logic                                    in_valid,
   input  wire logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] real_part,
   input  wire logic signed [r2p_pkg::SAMPLE_WIDTH-1:0] imag_part,
   output      logic                                    out_valid,
   output      r2p_pkg::cell_data_type                  out_data
);
   import r2p_pkg::*;

   // First stage: squares and quadrant fold.
   logic                         s1_valid_ff, s1_valid_in;
   logic [RAD_WIDTH-1:0]         s1_sq_re_ff, s1_sq_re_in;
   logic [RAD_WIDTH-1:0]         s1_sq_im_ff, s1_sq_im_in;
   logic signed [XY_WIDTH-1:0]   s1_x_ff, s1_x_in;
   logic signed [XY_WIDTH-1:0]   s1_y_ff, s1_y_in;
   logic [ANGLE_WIDTH-1:0]       s1_z_ff, s1_z_in;
   logic                         s1_zero_ff, s1_zero_in;

   // Second stage: radicand sum, first word of the chain.
   logic                         s2_valid_ff, s2_valid_in;
   cell_data_type                s2_data_ff, s2_data_in;

   logic signed [RAD_WIDTH-1:0]  prod_re;
   logic signed [RAD_WIDTH-1:0]  prod_im;
   logic signed [XY_WIDTH-1:0]   re_ext;
   logic signed [XY_WIDTH-1:0]   im_ext;

   always_comb begin
      prod_re = RAD_WIDTH'(real_part) * RAD_WIDTH'(real_part);
      prod_im = RAD_WIDTH'(imag_part) * RAD_WIDTH'(imag_part);
      re_ext  = XY_WIDTH'(real_part) <<< GUARD_BITS;
      im_ext  = XY_WIDTH'(imag_part) <<< GUARD_BITS;

      s1_valid_in = in_valid;
      s1_sq_re_in = prod_re;
      s1_sq_im_in = prod_im;
      s1_zero_in  = (real_part == '0) && (imag_part == '0);
      s1_x_in     = re_ext;
      s1_y_in     = im_ext;
      s1_z_in     = '0;
      // Fold the left half plane into the right one by a quarter turn.
      if (real_part < 0) begin
         if (imag_part >= 0) begin
            s1_x_in = im_ext;
            s1_y_in = -re_ext;
            s1_z_in = QUARTER_POS;
         end else begin
            s1_x_in = -im_ext;
            s1_y_in = re_ext;
            s1_z_in = QUARTER_NEG;
         end
      end

      s2_valid_in     = s1_valid_ff;
      s2_data_in.zero = s1_zero_ff;
      s2_data_in.x    = s1_x_ff;
      s2_data_in.y    = s1_y_ff;
      s2_data_in.z    = s1_z_ff;
      s2_data_in.rad  = s1_sq_re_ff + s1_sq_im_ff;
      s2_data_in.rem  = '0;
      s2_data_in.root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sq_re_ff <= s1_sq_re_in;
         s1_sq_im_ff <= s1_sq_im_in;
         s1_x_ff     <= s1_x_in;
         s1_y_ff     <= s1_y_in;
         s1_z_ff     <= s1_z_in;
         s1_zero_ff  <= s1_zero_in;
         s2_data_ff  <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

`default_nettype wire

// ===== sv/r2p_cell.sv =====
`default_nettype none

module r2p_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              advance,
   input  wire logic [r2p_pkg::IDX_WIDTH-1:0]     idx,
   input  wire logic                              in_valid,
   input  wire r2p_pkg::cell_data_type            in_data,
   output      logic                              out_valid,
   output      r2p_pkg::cell_data_type            out_data
);
   import r2p_pkg::*;

   logic           valid_ff, valid_in;
   cell_data_type  data_ff, data_in;

   logic signed [XY_WIDTH-1:0]  dx;
   logic signed [XY_WIDTH-1:0]  dy;
   logic [ANGLE_WIDTH-1:0]      angle;
   logic [REM_WIDTH+1:0]        rem_wide;
   logic [REM_WIDTH+1:0]        trial;

   always_comb begin
      data_in  = in_data;
      valid_in = in_valid;

      dx    = in_data.y >>> idx;
      dy    = in_data.x >>> idx;
      angle = atan_entry(int'(idx));

      // One micro-rotation that drives y toward zero.
      if (int'(idx) < CORDIC_USED) begin
         if (in_data.y >= 0) begin
            data_in.x = in_data.x + dx;
            data_in.y = in_data.y - dy;
            data_in.z = in_data.z + angle;
         end else begin
            data_in.x = in_data.x - dx;
            data_in.y = in_data.y + dy;
            data_in.z = in_data.z - angle;
         end
      end

      // One digit of the restoring square root: bring down two radicand bits.
      rem_wide = {in_data.rem, in_data.rad[RAD_WIDTH-1 -: 2]};
      trial    = {2'b00, in_data.root, 2'b01};
      if (int'(idx) < SQRT_STEPS) begin
         data_in.rad = in_data.rad << 2;
         if (rem_wide >= trial) begin
            data_in.rem  = REM_WIDTH'(rem_wide - trial);
            data_in.root = {in_data.root[ROOT_WIDTH-2:0], 1'b1};
         end else begin
            data_in.rem  = REM_WIDTH'(rem_wide);
            data_in.root = {in_data.root[ROOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== sv/r2p_back.sv =====
`default_nettype none

module r2p_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   advance,
   input  wire logic                                   in_valid,
   input  wire r2p_pkg::cell_data_type                 in_data,
   output      logic                                   out_valid,
   output      logic [r2p_pkg::SAMPLE_WIDTH-1:0]       magnitude,
   output      logic signed [r2p_pkg::PHASE_WIDTH-1:0] phase
);
   import r2p_pkg::*;

   logic                          valid_ff, valid_in;
   logic [SAMPLE_WIDTH-1:0]       mag_ff, mag_in;
   logic signed [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [ANGLE_WIDTH-1:0]        z_rounded;
   logic                          round_up;

   always_comb begin
      valid_in  = in_valid;
      // The floor root rounds up when the remainder exceeds it.
      round_up  = in_data.rem > REM_WIDTH'(in_data.root);
      mag_in    = SAMPLE_WIDTH'(in_data.root) + SAMPLE_WIDTH'(round_up);
      z_rounded = in_data.z + PHASE_HALF;
      phase_in  = z_rounded[ANGLE_WIDTH-1 -: PHASE_WIDTH];
      if (in_data.zero) begin
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_ff   <= mag_in;
         phase_ff <= phase_in;
      end
   end

   assign out_valid = valid_ff;
   assign magnitude = mag_ff;
   assign phase     = phase_ff;

endmodule

`default_nettype wire

// ===== sv/rectangular_to_polar.sv =====
// Rectangular to polar conversion of complex spectrum bins.
// The req_chan channel carries one bin per word as signed real_part and
// imag_part. The rsp_chan channel returns one word per bin, in order: the
// magnitude sqrt(re^2 + im^2) rounded to the nearest integer, and the phase
// atan2(im, re) in units of pi/32768, where +pi shows as -32768. A zero bin
// gives magnitude 0 and phase 0.
// The datapath is a fixed pipeline: two front stages form the squares and
// fold the vector into the right half plane, then a row of identical cells
// each performs one CORDIC micro-rotation and one square root digit, and a
// final stage rounds both results into the output register. One word is
// accepted every cycle while the pipeline advances. The pipeline advances
// as a whole; it holds only when the output register is full and the
// receiver is not ready, and req_chan ready drops in that cycle. The block
// keeps no state between words. A synchronous reset empties the pipeline;
// any words in flight are dropped.
`default_nettype none

module rectangular_to_polar (
   input  wire logic  clock,
   input  wire logic  reset,
   r2p_req_if.sink    req_chan,
   r2p_rsp_if.source  rsp_chan
);
   import r2p_pkg::*;

   // Whole-pipeline advance: the output register is free or is being taken.
   logic           advance;
   logic           front_valid;
   cell_data_type  front_data;
   logic           chain_valid [CELL_COUNT+1];
   cell_data_type  chain_data  [CELL_COUNT+1];

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   r2p_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .real_part (req_chan.real_part),
      .imag_part (req_chan.imag_part),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   assign chain_valid[0] = front_valid;
   assign chain_data[0]  = front_data;

   // Cell k applies micro-rotation k and square root digit k.
   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      r2p_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .idx       (IDX_WIDTH'(k)),
         .in_valid  (chain_valid[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   r2p_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (chain_valid[CELL_COUNT]),
      .in_data   (chain_data[CELL_COUNT]),
      .out_valid (rsp_chan.valid),
      .magnitude (rsp_chan.magnitude),
      .phase     (rsp_chan.phase)
   );

endmodule

`default_nettype wire

// ===== dv/tb_rectangular_to_polar.sv =====
`timescale 1ns / 1ps

module tb_rectangular_to_polar;
   import r2p_pkg::*;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   // One clock is 12 ns; the inputs move on the falling edge so that the
   // block sees settled values on every rising edge.
   localparam realtime HALF_PERIOD = 6ns;
   localparam int      RESET_CYCLES = 5;
   // The pipeline depth, plus a margin, bounds the quiet tail of the run.
   localparam int      PIPE_DEPTH = CELL_COUNT + 3;
   localparam int      SETTLE_CYCLES = PIPE_DEPTH + 12;
   localparam int      RANDOM_BINS = 1100;
   // Far above the slowest legal run: about 1125 words, each facing the
   // longest sender gap and the longest receiver stall.
   localparam int      CYCLE_LIMIT = 200000;

   // Directed bins: the origin, the ends of both axes, the four corners, the
   // negative real axis where the phase wraps from +pi to -32768, bins just
   // off that axis on either side, and a few ordinary points.
   localparam int      DIRECTED_BINS = 22;
   localparam sample_type DIRECTED_RE [DIRECTED_BINS] = '{
      16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd32767, -16'sd32768, 16'sd0,
      16'sd0, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, -16'sd32768,
      -16'sd32768, -16'sd1, -16'sd1, 16'sd1, -16'sd5, 16'sd3, -16'sd21846,
      16'sd12345
   };
   localparam sample_type DIRECTED_IM [DIRECTED_BINS] = '{
      16'sd0, 16'sd0, 16'sd1, 16'sd0, -16'sd1, 16'sd0, 16'sd0, 16'sd32767,
      -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd1,
      -16'sd1, 16'sd1, -16'sd1, -16'sd1, 16'sd0, 16'sd4, 16'sd21845,
      -16'sd23456
   };

   // The scoreboard predicts the polar word of every bin the block accepts
   // and compares each returned word, in order, against the oldest one.
   class polar_scoreboard;
      typedef struct {
         sample_type                    re;
         sample_type                    im;
         logic [SAMPLE_WIDTH-1:0]       magnitude;
         logic signed [PHASE_WIDTH-1:0] phase;
      } polar_word_type;

      polar_word_type pending[$];
      int          errors;
      int          bins_in;
      int          words_checked;
      int          zero_bins;
      int          wrap_bins;
      int          long_bins;

      // Rounded square root of re^2 + im^2. The floor root is built one bit
      // at a time; it rounds up when the remainder exceeds the root, which
      // is the same as the true root lying above root + 1/2.
      function automatic logic [SAMPLE_WIDTH-1:0] predict_magnitude(sample_type re,
                                                                  sample_type im);
         longint sum_sq;
         longint root;
         longint trial;
         sum_sq = longint'(re) * longint'(re) + longint'(im) * longint'(im);
         root = 0;
         for (int b = SAMPLE_WIDTH - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum_sq) begin
               root = trial;
            end
         end
         if (sum_sq - root * root > root) begin
            root = root + 1;
         end
         return root[SAMPLE_WIDTH-1:0];
      endfunction

      // CORDIC vectoring: fold the left half plane onto the right with a
      // quarter turn, then rotate y toward zero while summing the angles.
      // The angle is a 32-bit turn fraction; the top 16 bits, rounded, are
      // the phase.
      function automatic logic signed [PHASE_WIDTH-1:0] predict_phase(sample_type re,
                                                                     sample_type im);
         longint                 x;
         longint                 y;
         longint                 x_step;
         longint                 y_step;
         longint                 held;
         logic [ANGLE_WIDTH-1:0] angle;
         logic [ANGLE_WIDTH-1:0] rounded;
         int                     rotations;
         if (re == 0 && im == 0) begin
            return '0;
         end
         x = longint'(re) * (longint'(1) << GUARD_BITS);
         y = longint'(im) * (longint'(1) << GUARD_BITS);
         angle = '0;
         rotations = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;
         if (x < 0) begin
            held = x;
            if (y >= 0) begin
               x = y;
               y = -held;
               angle = QUARTER_POS;
            end else begin
               x = -y;
               y = held;
               angle = QUARTER_NEG;
            end
         end
         for (int i = 0; i < rotations; i++) begin
            // Arithmetic shifts of signed values round toward minus infinity.
            x_step = y >>> i;
            y_step = x >>> i;
            if (y >= 0) begin
               x = x + x_step;
               y = y - y_step;
               angle = angle + ATAN_TABLE[i];
            end else begin
               x = x - x_step;
               y = y + y_step;
               angle = angle - ATAN_TABLE[i];
            end
         end
         rounded = angle + PHASE_HALF;
         return rounded[ANGLE_WIDTH-1 -: PHASE_WIDTH];
      endfunction

      function void note_bin(sample_type re, sample_type im);
         polar_word_type word;
         word.re = re;
         word.im = im;
         word.magnitude = predict_magnitude(re, im);
         word.phase = predict_phase(re, im);
         pending.push_back(word);
         bins_in++;
         if (re == 0 && im == 0) begin
            zero_bins++;
         end
         if (re < 0 && im == 0) begin
            wrap_bins++;
         end
      endfunction

      function int pending_count();
         return pending.size();
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("[%0t] mismatch: %s", $realtime, what);
      endtask

      task check_word(logic [SAMPLE_WIDTH-1:0] magnitude,
                      logic signed [PHASE_WIDTH-1:0] phase);
         polar_word_type want;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("word mag=%0d phase=%0d with no bin pending",
                                      magnitude, phase));
            return;
         end
         want = pending.pop_front();
         words_checked++;
         if (want.magnitude > 32767) begin
            long_bins++;
         end
         if (magnitude !== want.magnitude) begin
            report_mismatch($sformatf("re=%0d im=%0d magnitude %0d, predicted %0d",
                                      want.re, want.im, magnitude, want.magnitude));
         end
         if (phase !== want.phase) begin
            report_mismatch($sformatf("re=%0d im=%0d phase %0d, predicted %0d",
                                      want.re, want.im, phase, want.phase));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   cycle_count;

   r2p_req_if req_chan ();
   r2p_rsp_if rsp_chan ();

   polar_scoreboard sb = new();

   rectangular_to_polar u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
   end

   always #(HALF_PERIOD) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Both monitors sample on the rising edge, when a word actually moves.
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         sb.note_bin(req_chan.real_part, req_chan.imag_part);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         sb.check_word(rsp_chan.magnitude, rsp_chan.phase);
      end
   end

   // The receiver switches between four stall patterns, drawn at random:
   // always ready, randomly ready about 70% of the time, a fixed rhythm that is
   // busy five eighths of the time, and rare long stalls.
   int stall_pattern;
   int pattern_age;
   int rhythm_count;
   int stall_left;

   initial begin
      stall_pattern = 0;
      pattern_age = 0;
      rhythm_count = 0;
      stall_left = 0;
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready = 1'b1;
      end else begin
         pattern_age++;
         rhythm_count++;
         if (pattern_age == 250) begin
            pattern_age = 0;
            stall_pattern = $urandom_range(0, 3);
         end
         case (stall_pattern)
            0: begin
               rsp_chan.ready = 1'b1;
            end
            1: begin
               rsp_chan.ready = ($urandom_range(0, 9) < 7);
            end
            2: begin
               rsp_chan.ready = ((rhythm_count % 8) >= 5);
            end
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_chan.ready = 1'b0;
               end else if ($urandom_range(0, 15) == 0) begin
                  stall_left = $urandom_range(10, 25);
                  rsp_chan.ready = 1'b0;
               end else begin
                  rsp_chan.ready = 1'b1;
               end
            end
         endcase
      end
   end

   // Presents one bin and holds it until the block takes it. Valid stays
   // high on return, so back-to-back calls form a burst.
   task automatic drive_bin(input sample_type re, input sample_type im);
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.real_part = re;
      req_chan.imag_part = im;
      do begin
         @(posedge clock);
      end while (!(req_chan.valid && req_chan.ready));
   endtask

   // Drops valid for a number of cycles and scrambles the idle payload,
   // which the block has to ignore.
   task automatic hold_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         req_chan.real_part = sample_type'($urandom);
         req_chan.imag_part = sample_type'($urandom);
      end
   endtask

   // Random bins come from several families so that the rare regions get
   // real weight: full-range values, tiny vectors near the origin, the axes,
   // the diagonals, mixes of directed values, bins hugging the negative real
   // axis where the phase flips between +pi and -pi, and mid-range values.
   task automatic pick_random_bin(output sample_type re, output sample_type im);
      int span;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            re = sample_type'($urandom);
            im = sample_type'($urandom);
         end
         4: begin
            re = sample_type'($urandom_range(0, 16) - 8);
            im = sample_type'($urandom_range(0, 16) - 8);
         end
         5: begin
            re = sample_type'($urandom);
            im = '0;
            if ($urandom_range(0, 1) == 1) begin
               im = re;
               re = '0;
            end
         end
         6: begin
            span = $urandom_range(1, 32767);
            re = ($urandom_range(0, 1) == 1) ? sample_type'(-span) : sample_type'(span);
            im = ($urandom_range(0, 1) == 1) ? sample_type'(-span) : sample_type'(span);
         end
         7: begin
            re = DIRECTED_RE[$urandom_range(0, DIRECTED_BINS - 1)];
            im = DIRECTED_IM[$urandom_range(0, DIRECTED_BINS - 1)];
         end
         8: begin
            re = sample_type'(-int'($urandom_range(1, 32768)));
            im = sample_type'($urandom_range(0, 6) - 3);
         end
         default: begin
            re = sample_type'($urandom_range(0, 2047) - 1024);
            im = sample_type'($urandom_range(0, 2047) - 1024);
         end
      endcase
   endtask

   // A watchdog ends a run that has hung.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
      end
      $display("timeout after %0d cycles with %0d words outstanding",
               cycle_count, sb.pending_count());
      $display("FAIL rectangular_to_polar");
      $finish;
   end

   initial begin
      sample_type re;
      sample_type im;
      int      sent;
      int      burst;

      // Every input is known from time zero; reset is held and then released
      // on a falling edge.
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.real_part = '0;
      req_chan.imag_part = '0;
      rsp_chan.ready = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed bins go in back to back.
      for (int i = 0; i < DIRECTED_BINS; i++) begin
         drive_bin(DIRECTED_RE[i], DIRECTED_IM[i]);
      end

      // Random bins go in bursts of random length separated by gaps that are
      // mostly absent or short and now and then long. Halfway through, the
      // sender waits until the pipeline has drained completely.
      sent = 0;
      while (sent < RANDOM_BINS) begin
         burst = $urandom_range(1, 48);
         for (int k = 0; k < burst && sent < RANDOM_BINS; k++) begin
            pick_random_bin(re, im);
            drive_bin(re, im);
            sent++;
            if (sent == RANDOM_BINS / 2) begin
               hold_sender(1);
               while (sb.pending_count() != 0) begin
                  @(posedge clock);
               end
            end
         end
         case ($urandom_range(0, 3))
            0: begin
            end
            1, 2: begin
               hold_sender($urandom_range(1, 3));
            end
            default: begin
               hold_sender($urandom_range(4, 16));
            end
         endcase
      end
      hold_sender(1);

      // Wait for the last words, then give the pipeline time to show any
      // stray word it should not produce.
      while (sb.pending_count() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.pending_count() != 0) begin
         sb.report_mismatch($sformatf("%0d bins never answered", sb.pending_count()));
      end
      $display("Converted %0d bins and checked %0d words, %0d mismatches.",
               sb.bins_in, sb.words_checked, sb.errors);
      $display("Covered %0d zero bins, %0d on the negative real axis, %0d above 32767.",
               sb.zero_bins, sb.wrap_bins, sb.long_bins);
      if (sb.errors == 0) begin
         $display("PASS rectangular_to_polar");
      end else begin
         $display("FAIL rectangular_to_polar");
      end
      $finish;
   end

endmodule
